@@ hdl/dsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and constants for the DMX slot capture RGB dimmer.
// ----------------------------------------------------------------------------
package dsc_pkg;

   // captured window
   localparam int SLOT_COUNT = 4;
   localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
   localparam int ADDR_W     = 9;
   localparam int CNT_W      = 10;
   localparam int LEVEL_W    = 8;
   localparam int PHASE_W    = 2;

   // captured slot roles
   localparam logic [SLOT_IDX_W-1:0] SLOT_MASTER = SLOT_IDX_W'(0);
   localparam logic [SLOT_IDX_W-1:0] SLOT_RED    = SLOT_IDX_W'(1);
   localparam logic [SLOT_IDX_W-1:0] SLOT_GREEN  = SLOT_IDX_W'(2);
   localparam logic [SLOT_IDX_W-1:0] SLOT_BLUE   = SLOT_IDX_W'(3);

   // frame phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_BREAK = 2'd1;
   localparam logic [PHASE_W-1:0] PH_SLOTS = 2'd2;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'hFF;
   localparam logic [LEVEL_W-1:0] START_CODE = 8'h00;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       framing_error;
      logic       overrun;
   } dsc_req_type;

   typedef struct packed {
      logic [7:0] red_level;
      logic [7:0] green_level;
      logic [7:0] blue_level;
      logic [1:0] frame_phase;
   } dsc_rsp_type;

   // state after one transaction, handed to the dimmer
   typedef struct packed {
      logic [LEVEL_W-1:0] master;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic [PHASE_W-1:0] phase;
   } dsc_snap_type;

endpackage

@@ hdl/dsc_frame_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_frame_tracker
// Frame phase, slot counter and captured slot store; registers a snapshot
// of the updated state for each transaction.
// ----------------------------------------------------------------------------
module dsc_frame_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  dsc_pkg::dsc_req_type        item,
   input  logic [dsc_pkg::ADDR_W-1:0]  start_address,
   input  logic                        snap_ready,
   output logic                        item_taken,
   output logic                        snap_valid,
   output dsc_pkg::dsc_snap_type       snap
);
   import dsc_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CNT_W-1:0]   slot_count_ff, slot_count_in;
   logic [LEVEL_W-1:0] slots_ff [SLOT_COUNT];
   logic [LEVEL_W-1:0] slots_in [SLOT_COUNT];
   logic               snap_valid_ff;
   dsc_snap_type       snap_ff;

   logic               snap_load;
   logic               advance;
   logic [CNT_W-1:0]   win_start;
   logic [CNT_W-1:0]   win_end;
   logic [CNT_W-1:0]   win_offset;
   logic               in_window;

   // pipeline control
   assign snap_load  = !snap_valid_ff || snap_ready;
   assign advance    = item_valid && snap_load;
   assign item_taken = snap_load;

   // capture window bounds
   assign win_start  = CNT_W'(start_address);
   assign win_end    = win_start + CNT_W'(SLOT_COUNT);
   assign win_offset = slot_count_ff - win_start;
   assign in_window  = (slot_count_ff >= win_start) && (slot_count_ff < win_end);

   // next state for one character
   always_comb begin
      phase_in      = phase_ff;
      slot_count_in = slot_count_ff;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slots_in[i] = slots_ff[i];
      end
      if (item.framing_error) begin
         slot_count_in = '0;
         phase_in      = PH_BREAK;
      end else if (item.overrun) begin
         slot_count_in = '0;
         phase_in      = PH_IDLE;
      end else begin
         case (phase_ff)
            PH_BREAK: begin
               phase_in = (item.rx_byte == START_CODE) ? PH_SLOTS : PH_IDLE;
            end
            PH_SLOTS: begin
               if (in_window) begin
                  slots_in[win_offset[SLOT_IDX_W-1:0]] = item.rx_byte;
               end
               if (slot_count_ff >= win_end) begin
                  phase_in = PH_IDLE;
               end else begin
                  slot_count_in = slot_count_ff + CNT_W'(1);
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         slot_count_ff <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slots_ff[i] <= '0;
         end
      end else if (advance) begin
         phase_ff      <= phase_in;
         slot_count_ff <= slot_count_in;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slots_ff[i] <= slots_in[i];
         end
      end
   end

   // snapshot stage
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (snap_load) begin
         snap_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         snap_ff.master <= slots_in[SLOT_MASTER];
         snap_ff.red    <= slots_in[SLOT_RED];
         snap_ff.green  <= slots_in[SLOT_GREEN];
         snap_ff.blue   <= slots_in[SLOT_BLUE];
         snap_ff.phase  <= (phase_in == PH_BREAK || phase_in == PH_SLOTS) ?
                           phase_in : PH_IDLE;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

@@ hdl/dsc_master_dimmer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_master_dimmer
// Scales red, green and blue by master/255 (floor) and holds the result
// transaction in the output register.
// ----------------------------------------------------------------------------
module dsc_master_dimmer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   snap_valid,
   input  dsc_pkg::dsc_snap_type  snap,
   output logic                   snap_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dsc_pkg::dsc_rsp_type   rsp_data
);
   import dsc_pkg::*;

   logic         rsp_valid_ff;
   dsc_rsp_type  rsp_data_ff, rsp_data_in;
   logic         out_load;

   // floor(level * master / 255); exact for products below 65535
   function automatic logic [LEVEL_W-1:0] dim_level(input logic [LEVEL_W-1:0] level,
                                                    input logic [LEVEL_W-1:0] master);
      logic [2*LEVEL_W-1:0] prod;
      logic [2*LEVEL_W:0]   sum;
      begin
         prod = (2*LEVEL_W)'(level) * (2*LEVEL_W)'(master);
         sum  = (2*LEVEL_W+1)'(prod) + (2*LEVEL_W+1)'(prod >> LEVEL_W)
                + (2*LEVEL_W+1)'(1);
         if (master == LEVEL_FULL) begin
            dim_level = level;
         end else begin
            dim_level = sum[2*LEVEL_W-1:LEVEL_W];
         end
      end
   endfunction

   // result transaction
   always_comb begin
      rsp_data_in.red_level   = dim_level(snap.red, snap.master);
      rsp_data_in.green_level = dim_level(snap.green, snap.master);
      rsp_data_in.blue_level  = dim_level(snap.blue, snap.master);
      rsp_data_in.frame_phase = snap.phase;
   end

   assign out_load   = !rsp_valid_ff || !rsp_stall;
   assign snap_ready = out_load;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && snap_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/dmx_slot_capture_rgb_dimmer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_slot_capture_rgb_dimmer
// DMX512 slot capture with master-dimmed RGB output.
//
// Each req transaction carries one received character with its framing
// error (break) and overrun flags. Every transaction gives exactly one rsp
// transaction: red, green and blue scaled by the captured master slot, and
// the frame phase after the character was applied.
// csr_wr_en / csr_wr_data load the start address (slot of the master
// channel); write it only while no transaction is in flight.
// rsp_valid rises behind three register stages: input register (loaded on
// the edge that accepts a req transaction), state update with snapshot
// register, dimming multipliers with output register.
// A new transaction is accepted every cycle while rsp_stall is low.
// rsp_stall holds the output register; the stages behind it keep filling,
// and req_stall rises once the input register cannot move on.
// Synchronous reset clears the phase, slot counter, captured slots, start
// address and all valid flags.
// ----------------------------------------------------------------------------
module dmx_slot_capture_rgb_dimmer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  dsc_pkg::dsc_req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output dsc_pkg::dsc_rsp_type        rsp_data,
   input  logic                        csr_wr_en,
   input  logic [dsc_pkg::ADDR_W-1:0]  csr_wr_data
);
   import dsc_pkg::*;

   logic               in_valid_ff;
   dsc_req_type        in_data_ff;
   logic [ADDR_W-1:0]  start_address_ff;
   logic               item_taken;
   logic               in_load;
   logic               snap_valid;
   logic               snap_ready;
   dsc_snap_type       snap;

   // start address register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff <= '0;
      end else if (csr_wr_en) begin
         start_address_ff <= csr_wr_data;
      end
   end

   // input register
   assign in_load   = !in_valid_ff || item_taken;
   assign req_stall = !in_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // frame tracking and slot capture
   dsc_frame_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (in_valid_ff),
      .item          (in_data_ff),
      .start_address (start_address_ff),
      .snap_ready    (snap_ready),
      .item_taken    (item_taken),
      .snap_valid    (snap_valid),
      .snap          (snap)
   );

   // master dimming and output register
   dsc_master_dimmer u_dimmer (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_ready (snap_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

@@ test/dsc_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_frame_checker
// Watches both channels and the start address port of the DMX slot capture
// dimmer. It tracks its own copy of the frame state and predicts the dimmed
// levels and frame phase for every accepted character, then compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module dsc_frame_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  dsc_pkg::dsc_req_type        req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  dsc_pkg::dsc_rsp_type        rsp_data,
   input  logic                        csr_wr_en,
   input  logic [dsc_pkg::ADDR_W-1:0]  csr_wr_data,
   output int                          fail_count,
   output int                          pending_count,
   output int                          results_checked
);
   import dsc_pkg::*;

   // predicted frame state
   logic [ADDR_W-1:0]  start_addr_q;
   logic [PHASE_W-1:0] phase_q;
   logic [CNT_W-1:0]   slot_cnt_q;
   logic [LEVEL_W-1:0] slots_q [SLOT_COUNT];

   // levels and phase still owed by the block, oldest first
   dsc_rsp_type expected_levels [$];

   // master dimming with floor, full master passes the level through
   function automatic logic [LEVEL_W-1:0] dimmed(input logic [LEVEL_W-1:0] level,
                                                 input logic [LEVEL_W-1:0] master);
      logic [2*LEVEL_W-1:0] product;
      if (master == LEVEL_FULL) return level;
      product = level * master;
      return LEVEL_W'(product / 16'd255);
   endfunction

   // apply one character to the frame state and queue the levels it gives
   task automatic apply_char(input dsc_req_type item);
      logic [CNT_W-1:0] window_end;
      dsc_rsp_type      outcome;
      window_end = CNT_W'(start_addr_q) + CNT_W'(SLOT_COUNT);
      if (item.framing_error) begin
         // break wins over an overrun on the same character
         slot_cnt_q = '0;
         phase_q    = PH_BREAK;
      end else if (item.overrun) begin
         slot_cnt_q = '0;
         phase_q    = PH_IDLE;
      end else if (phase_q == PH_BREAK) begin
         phase_q = (item.rx_byte == START_CODE) ? PH_SLOTS : PH_IDLE;
      end else if (phase_q == PH_SLOTS) begin
         if (slot_cnt_q >= CNT_W'(start_addr_q) && slot_cnt_q < window_end)
            slots_q[SLOT_IDX_W'(slot_cnt_q - CNT_W'(start_addr_q))] = item.rx_byte;
         // character past the window closes the frame
         if (slot_cnt_q >= window_end)
            phase_q = PH_IDLE;
         else
            slot_cnt_q = slot_cnt_q + 1'b1;
      end
      outcome.red_level   = dimmed(slots_q[SLOT_RED], slots_q[SLOT_MASTER]);
      outcome.green_level = dimmed(slots_q[SLOT_GREEN], slots_q[SLOT_MASTER]);
      outcome.blue_level  = dimmed(slots_q[SLOT_BLUE], slots_q[SLOT_MASTER]);
      outcome.frame_phase = phase_q;
      expected_levels.push_back(outcome);
   endtask

   task automatic report_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: mismatch on %s, expected %0d, actual %0d", $time, field,
                  want, got);
         fail_count++;
      end
   endtask

   // compare every accepted result, then track config and new characters
   always @(posedge clock) begin
      dsc_rsp_type want;
      if (reset) begin
         start_addr_q    = '0;
         phase_q         = PH_IDLE;
         slot_cnt_q      = '0;
         for (int s = 0; s < SLOT_COUNT; s++) slots_q[s] = '0;
         expected_levels.delete();
         fail_count      = 0;
         results_checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $display("%0t ns: result with no transaction waiting, actual %h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_levels.pop_front();
               report_field("red_level", want.red_level, rsp_data.red_level);
               report_field("green_level", want.green_level, rsp_data.green_level);
               report_field("blue_level", want.blue_level, rsp_data.blue_level);
               report_field("frame_phase", want.frame_phase, rsp_data.frame_phase);
               results_checked++;
            end
         end
         if (csr_wr_en) start_addr_q = csr_wr_data;
         if (req_valid && !req_stall) apply_char(req_data);
      end
      pending_count = expected_levels.size();
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives DMX characters into the slot capture dimmer: a directed pass over
// breaks, start codes, overruns and window ends, then random frames under
// several start addresses from 0 to 511, with idle gaps on both sides, a
// long receiver hold-off and drains between settings. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import dsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES    = 80;
   localparam int TAIL_CYCLES    = 8;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   dsc_req_type         req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   dsc_rsp_type         rsp_data;
   logic                csr_wr_en;
   logic [ADDR_W-1:0]   csr_wr_data;

   int fail_count;
   int pending_count;
   int results_checked;

   int chars_sent;
   int frames_complete;
   int settings_used;
   int current_start;
   int idle_cycles;
   bit calm_stretch;
   bit hold_request;

   dmx_slot_capture_rgb_dimmer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   dsc_frame_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .results_checked (results_checked)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side: random stalls, calm stretches and one long hold-off
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (calm_stretch) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 13);
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t ns: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench: FAIL");
      $finish;
   end

   // slot data leaning on the dimmer extremes
   function automatic logic [7:0] pick_slot_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return LEVEL_FULL;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // offer one character, starting and ending at a falling edge
   task automatic send_char(input logic [7:0] rx, input logic brk, input logic ovr);
      dsc_req_type item;
      item.rx_byte       = rx;
      item.framing_error = brk;
      item.overrun       = ovr;
      while (!calm_stretch && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
      @(negedge clock);
   endtask

   // sender pauses until the block has returned everything
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_start_address(input int addr);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ADDR_W'(addr);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      current_start = addr;
      settings_used++;
   endtask

   // one frame: mostly well formed, some cut short, bad start codes and noise
   task automatic send_frame(input bit force_good);
      int kind;
      int length;
      kind = force_good ? 0 : $urandom_range(99);
      if (kind >= 90) begin
         // noise with random flags
         repeat ($urandom_range(8, 1))
            send_char(8'($urandom_range(255)), $urandom_range(9) == 0,
                      $urandom_range(9) == 0);
         return;
      end
      // break, now and then with an overrun on the same character
      send_char(pick_slot_byte(), 1'b1, $urandom_range(3) == 0);
      if (kind >= 75) begin
         // wrong start code, the rest lands while idle
         send_char(8'($urandom_range(255, 1)), 1'b0, 1'b0);
         repeat ($urandom_range(4)) send_char(pick_slot_byte(), 1'b0, 1'b0);
         return;
      end
      send_char(START_CODE, 1'b0, 1'b0);
      length = current_start + SLOT_COUNT + $urandom_range(3);
      if (kind >= 55) length = $urandom_range(length);
      repeat (length) send_char(pick_slot_byte(), 1'b0, 1'b0);
      // overrun abandons the frame
      if (kind >= 55 && kind < 65)
         send_char(8'($urandom_range(255)), 1'b0, 1'b1);
      if (length >= current_start + SLOT_COUNT) frames_complete++;
   endtask

   task automatic run_phase(input int addr, input int budget, input bit with_hold);
      int target;
      wait_for_results();
      write_start_address(addr);
      target = chars_sent + budget;
      send_frame(1'b1);
      if (with_hold) hold_request = 1'b1;
      while (chars_sent < target) send_frame(1'b0);
   endtask

   // stimulus and verdict
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      calm_stretch    = 1'b0;
      hold_request    = 1'b0;
      chars_sent      = 0;
      frames_complete = 0;
      settings_used   = 0;
      current_start   = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed pass with the window at slot zero
      write_start_address(0);
      send_char(8'hFF, 1'b0, 1'b0);          // character while idle
      send_char(8'h00, 1'b1, 1'b0);          // break
      send_char(START_CODE, 1'b0, 1'b0);
      send_char(LEVEL_FULL, 1'b0, 1'b0);     // full master passes levels through
      send_char(LEVEL_FULL, 1'b0, 1'b0);
      send_char(8'h00, 1'b0, 1'b0);
      send_char(8'h80, 1'b0, 1'b0);
      send_char(8'h5A, 1'b0, 1'b0);          // end of window
      send_char(8'h55, 1'b0, 1'b0);          // idle again
      send_char(8'hFF, 1'b1, 1'b1);          // break and overrun together
      send_char(8'h01, 1'b0, 1'b0);          // non-zero start code
      send_char(8'h00, 1'b0, 1'b1);          // overrun while idle
      send_char(8'h00, 1'b1, 1'b0);
      send_char(START_CODE, 1'b0, 1'b0);
      send_char(8'h80, 1'b0, 1'b0);
      send_char(LEVEL_FULL, 1'b0, 1'b0);
      send_char(8'h33, 1'b0, 1'b1);          // overrun abandons a partial frame
      send_char(8'h00, 1'b1, 1'b0);
      send_char(START_CODE, 1'b0, 1'b0);
      send_char(8'hFE, 1'b0, 1'b0);
      send_char(LEVEL_FULL, 1'b0, 1'b0);
      send_char(8'h01, 1'b0, 1'b0);
      send_char(8'hFE, 1'b0, 1'b0);
      send_char(8'h00, 1'b0, 1'b0);          // end of window

      // random frames under several start addresses
      run_phase(3, 190, 1'b0);
      calm_stretch = 1'b1;
      run_phase(0, 190, 1'b0);
      wait_for_results();
      calm_stretch = 1'b0;
      run_phase(511, 400, 1'b0);
      run_phase(1, 200, 1'b1);
      run_phase($urandom_range(12), 190, 1'b0);

      wait_for_results();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("summary: %0d characters over %0d start address settings (0 to 511),",
               chars_sent, settings_used);
      $display("summary: %0d frames through the window, %0d results checked with %s",
               frames_complete, results_checked, "idle gaps, a long hold-off and drains");
      if (fail_count == 0 && pending_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
